// File: rtl/core/edfs_pkg.sv
// edfs_pkg: shared types and constants for the edf periodic task scheduler
// holds the datapath command encoding and the task word layout
// no dependencies
package edfs_pkg;

    localparam int TASK_IDX_W = 3;
    localparam int CFG_WIDTH  = 48;
    localparam int EXEC_LSB   = 16;
    localparam int JOBS_LSB   = 32;
    localparam logic [3:0] IDLE_TASK = 4'd8;

    typedef enum logic [1:0] {
        OP_NONE,
        OP_RUN,
        OP_SCAN,
        OP_FINISH
    } dp_op_t;

    typedef struct packed {
        dp_op_t                  op;
        logic [TASK_IDX_W-1:0]   idx;
        logic                    first;
        logic                    restart;
    } dp_cmd_t;

endpackage

// File: rtl/core/edf_periodic_task_scheduler.sv
// edf_periodic_task_scheduler: preemptive earliest-deadline-first scheduler
// top level, joins edfs_ctrl and edfs_datapath; depends on edfs_pkg
//
//  channel  | handshake          | payload
//  ---------+--------------------+------------------------------------------
//  input    | in_valid/in_ready  | restart
//  output   | out_valid/out_ready| running_task .. done_count
//  config   | cfg_we             | cfg_index, cfg_data
//
// a result is loaded on the finish step, after the run step and the scan steps of its beat
// a new beat is taken only from idle, once the last one has been through its steps:
// one run step, one scan step per task slot, one finish step, then the idle state
// reset clears all task state, the totals and the config words; no clearing pass
// a result waiting on out_ready holds the next finish step; one new beat is taken meanwhile
module edf_periodic_task_scheduler
    import edfs_pkg::*;
#(
    parameter int NUM_TASKS   = 8,
    parameter int COUNT_WIDTH = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [TASK_IDX_W-1:0]  cfg_index,
    input  logic [CFG_WIDTH-1:0]   cfg_data,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic                   restart,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [3:0]             running_task,
    output logic [7:0]             released_mask,
    output logic                   finished,
    output logic [2:0]             finished_task,
    output logic                   preempted,
    output logic [2:0]             preempted_task,
    output logic [7:0]             missed_mask,
    output logic                   all_done,
    output logic [15:0]            miss_count,
    output logic [15:0]            done_count
);

    dp_cmd_t cmd;

    edfs_ctrl #(
        .NUM_TASKS (NUM_TASKS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .restart   (restart),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd)
    );

    edfs_datapath #(
        .NUM_TASKS   (NUM_TASKS),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .cmd            (cmd),
        .running_task   (running_task),
        .released_mask  (released_mask),
        .finished       (finished),
        .finished_task  (finished_task),
        .preempted      (preempted),
        .preempted_task (preempted_task),
        .missed_mask    (missed_mask),
        .all_done       (all_done),
        .miss_count     (miss_count),
        .done_count     (done_count)
    );

    // one beat in flight at a time
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("beat accepted while another is in flight");

    // a job cannot both finish and be displaced
    a_fin_pre_excl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(finished && preempted))
        else $error("finished and preempted in one tick");

    // the displacing task differs from the displaced one
    a_preempt_other: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && preempted) |-> (running_task != {1'b0, preempted_task}))
        else $error("task preempted by itself");

    // running task is a real slot or idle
    a_running_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (running_task <= IDLE_TASK))
        else $error("running task out of range");

endmodule

// File: rtl/core/edfs_ctrl.sv
// edfs_ctrl: sequencer for the scheduler, one item at a time
// walks run, per-task scan and finish steps; owns the handshakes
// depends on edfs_pkg
module edfs_ctrl
    import edfs_pkg::*;
#(
    parameter int NUM_TASKS = 8
) (
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    input  logic    restart,
    output logic    out_valid,
    input  logic    out_ready,
    output dp_cmd_t cmd
);

    localparam int IW = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_SCAN,
        S_FINISH
    } state_t;

    state_t          state_reg;
    logic [IW-1:0]   cnt_reg;
    logic            restart_reg;
    logic            out_valid_reg;
    logic            load_out;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign load_out  = (state_reg == S_FINISH) && (!out_valid_reg || out_ready);

    always_comb
    begin
        cmd.idx     = TASK_IDX_W'(cnt_reg);
        cmd.first   = (cnt_reg == '0);
        cmd.restart = restart_reg;
        unique case (state_reg)
            S_RUN:    cmd.op = OP_RUN;
            S_SCAN:   cmd.op = OP_SCAN;
            S_FINISH: cmd.op = load_out ? OP_FINISH : OP_NONE;
            default:  cmd.op = OP_NONE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            restart_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load_out)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        restart_reg <= restart;
                        state_reg   <= S_RUN;
                    end
                end
                S_RUN:
                begin
                    cnt_reg   <= '0;
                    state_reg <= S_SCAN;
                end
                S_SCAN:
                begin
                    if (cnt_reg == IW'(NUM_TASKS - 1))
                        state_reg <= S_FINISH;
                    else
                        cnt_reg <= cnt_reg + 1'b1;
                end
                S_FINISH:
                begin
                    if (load_out)
                        state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

// File: rtl/core/edfs_datapath.sv
// edfs_datapath: task tables, config words, running totals and result register
// one task slot is updated and ranked per scan step
// depends on edfs_pkg
module edfs_datapath
    import edfs_pkg::*;
#(
    parameter int NUM_TASKS   = 8,
    parameter int COUNT_WIDTH = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [TASK_IDX_W-1:0]  cfg_index,
    input  logic [CFG_WIDTH-1:0]   cfg_data,
    input  dp_cmd_t                cmd,
    output logic [3:0]             running_task,
    output logic [7:0]             released_mask,
    output logic                   finished,
    output logic [2:0]             finished_task,
    output logic                   preempted,
    output logic [2:0]             preempted_task,
    output logic [7:0]             missed_mask,
    output logic                   all_done,
    output logic [15:0]            miss_count,
    output logic [15:0]            done_count
);

    localparam int IW = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
    localparam int CW = COUNT_WIDTH;

    logic [CFG_WIDTH-1:0] task_word_reg [NUM_TASKS];
    logic [CW-1:0]        countdown_reg [NUM_TASKS];
    logic [CW-1:0]        work_reg      [NUM_TASKS];
    logic [CW-1:0]        jobs_reg      [NUM_TASKS];
    logic [NUM_TASKS-1:0] pending_reg;

    logic [3:0]           cur_reg;
    logic [CW-1:0]        miss_total_reg;
    logic [CW-1:0]        done_total_reg;
    logic                 cont_reg;
    logic                 fin_reg;
    logic [2:0]           fin_task_reg;
    logic [NUM_TASKS-1:0] released_reg;
    logic [NUM_TASKS-1:0] missed_reg;
    logic [3:0]           best_reg;
    logic [CW-1:0]        best_cd_reg;
    logic [CW-1:0]        cur_cd_reg;
    logic                 done_acc_reg;

    logic [3:0]           running_task_reg;
    logic [7:0]           released_mask_reg;
    logic                 finished_reg;
    logic [2:0]           finished_task_reg;
    logic                 preempted_reg;
    logic [2:0]           preempted_task_reg;
    logic [7:0]           missed_mask_reg;
    logic                 all_done_reg;
    logic [15:0]          miss_count_reg;
    logic [15:0]          done_count_reg;

    logic [IW-1:0]        sel;
    logic                 cur_valid;
    logic                 sel_is_cur;
    logic [CFG_WIDTH-1:0] word;
    logic [CW-1:0]        period;
    logic [CW-1:0]        exec_raw;
    logic [CW-1:0]        exec_time;
    logic [CW-1:0]        jobs;
    logic [CW-1:0]        cd;
    logic [CW-1:0]        wl;
    logic [CW-1:0]        jl;
    logic                 pend;
    logic [CW-1:0]        wl_dec;
    logic                 expire;
    logic [CW-1:0]        cd_next;
    logic [CW-1:0]        wl_next;
    logic [CW-1:0]        jl_next;
    logic                 pend_next;
    logic                 rel_bit;
    logic                 miss_bit;
    logic [3:0]           best_base;
    logic                 take;
    logic                 done_base;
    logic                 do_preempt;
    logic [3:0]           cur_next;

    assign sel        = (cmd.op == OP_RUN) ? cur_reg[IW-1:0] : cmd.idx[IW-1:0];
    assign cur_valid  = (cur_reg < 4'(NUM_TASKS));
    assign sel_is_cur = (cur_reg == 4'(sel));
    assign word       = task_word_reg[sel];
    assign period     = word[CW-1:0];
    assign exec_raw   = word[EXEC_LSB +: CW];
    assign exec_time  = (exec_raw == '0) ? CW'(1) : exec_raw;
    assign jobs       = word[JOBS_LSB +: CW];
    assign cd         = countdown_reg[sel];
    assign wl         = work_reg[sel];
    assign jl         = jobs_reg[sel];
    assign pend       = pending_reg[sel];
    assign wl_dec     = (wl != '0) ? wl - 1'b1 : wl;
    assign expire     = (cd == CW'(1));

    // per-slot update for restart or tick
    always_comb
    begin
        cd_next   = cd;
        wl_next   = wl;
        jl_next   = jl;
        pend_next = pend;
        rel_bit   = 1'b0;
        miss_bit  = 1'b0;
        if (cmd.restart)
        begin
            rel_bit   = (period != '0) && (jobs != '0);
            pend_next = rel_bit;
            wl_next   = rel_bit ? exec_time : '0;
            jl_next   = rel_bit ? jobs - 1'b1 : '0;
            cd_next   = rel_bit ? period : '0;
        end
        else
        begin
            if (cd != '0)
                cd_next = cd - 1'b1;
            if (expire && pend)
            begin
                miss_bit  = 1'b1;
                pend_next = 1'b0;
            end
            if (expire && (period != '0) && (jl != '0))
            begin
                rel_bit   = 1'b1;
                pend_next = 1'b1;
                wl_next   = exec_time;
                jl_next   = jl - 1'b1;
                cd_next   = period;
            end
        end
    end

    // running earliest-deadline search over the scan
    assign best_base = cmd.first ? IDLE_TASK : best_reg;
    assign done_base = cmd.first ? 1'b1 : done_acc_reg;
    assign take      = pend_next && ((best_base == IDLE_TASK) || (cd_next < best_cd_reg));

    assign do_preempt = cont_reg && (best_reg != IDLE_TASK) && (best_cd_reg < cur_cd_reg);
    assign cur_next   = (!cont_reg || do_preempt) ? best_reg : cur_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_TASKS; i++)
            begin
                task_word_reg[i] <= '0;
                countdown_reg[i] <= '0;
                work_reg[i]      <= '0;
                jobs_reg[i]      <= '0;
            end
            pending_reg    <= '0;
            cur_reg        <= IDLE_TASK;
            miss_total_reg <= '0;
            done_total_reg <= '0;
            cont_reg       <= 1'b0;
            fin_reg        <= 1'b0;
            fin_task_reg   <= '0;
            released_reg   <= '0;
            missed_reg     <= '0;
            best_reg       <= IDLE_TASK;
            best_cd_reg    <= '0;
            cur_cd_reg     <= '0;
            done_acc_reg   <= 1'b1;
        end
        else
        begin
            if (cfg_we && ({1'b0, cfg_index} < 4'(NUM_TASKS)))
                task_word_reg[cfg_index[IW-1:0]] <= cfg_data;
            unique case (cmd.op)
                OP_RUN:
                begin
                    released_reg <= '0;
                    missed_reg   <= '0;
                    fin_reg      <= 1'b0;
                    fin_task_reg <= '0;
                    cont_reg     <= 1'b0;
                    if (cmd.restart)
                    begin
                        miss_total_reg <= '0;
                        done_total_reg <= '0;
                    end
                    else if (cur_valid && pend)
                    begin
                        work_reg[sel] <= wl_dec;
                        if (wl_dec == '0)
                        begin
                            pending_reg[sel] <= 1'b0;
                            fin_reg          <= 1'b1;
                            fin_task_reg     <= cur_reg[2:0];
                            if (done_total_reg != '1)
                                done_total_reg <= done_total_reg + 1'b1;
                        end
                        else
                            cont_reg <= 1'b1;
                    end
                end
                OP_SCAN:
                begin
                    countdown_reg[sel] <= cd_next;
                    work_reg[sel]      <= wl_next;
                    jobs_reg[sel]      <= jl_next;
                    pending_reg[sel]   <= pend_next;
                    released_reg[sel]  <= rel_bit;
                    missed_reg[sel]    <= miss_bit;
                    if (miss_bit)
                    begin
                        if (miss_total_reg != '1)
                            miss_total_reg <= miss_total_reg + 1'b1;
                        if (sel_is_cur)
                            cont_reg <= 1'b0;
                    end
                    if (sel_is_cur)
                        cur_cd_reg <= cd_next;
                    if (take)
                    begin
                        best_reg    <= 4'(sel);
                        best_cd_reg <= cd_next;
                    end
                    else
                        best_reg <= best_base;
                    done_acc_reg <= done_base && !pend_next && (jl_next == '0);
                end
                OP_FINISH:
                begin
                    cur_reg <= cur_next;
                end
                default: ;
            endcase
        end
    end

    // result register, loaded on the finish step
    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_FINISH)
        begin
            running_task_reg   <= cur_next;
            released_mask_reg  <= 8'(released_reg);
            finished_reg       <= fin_reg;
            finished_task_reg  <= fin_task_reg;
            preempted_reg      <= do_preempt;
            preempted_task_reg <= do_preempt ? cur_reg[2:0] : 3'd0;
            missed_mask_reg    <= 8'(missed_reg);
            all_done_reg       <= done_acc_reg;
            miss_count_reg     <= 16'(miss_total_reg);
            done_count_reg     <= 16'(done_total_reg);
        end
    end

    assign running_task   = running_task_reg;
    assign released_mask  = released_mask_reg;
    assign finished       = finished_reg;
    assign finished_task  = finished_task_reg;
    assign preempted      = preempted_reg;
    assign preempted_task = preempted_task_reg;
    assign missed_mask    = missed_mask_reg;
    assign all_done       = all_done_reg;
    assign miss_count     = miss_count_reg;
    assign done_count     = done_count_reg;

endmodule
